// File: rtl/rpn_pkg.sv
// rpn_pkg: shared types and codes for the rpn stack evaluator
// holds beat payload structs, action/kind/error codes, datapath commands and fsm states
// no dependencies
package rpn_pkg;

   // input action codes (values above ACT_EOL are unknown commands)
   localparam logic [3:0] ACT_NUMBER = 4'd0;
   localparam logic [3:0] ACT_ADD    = 4'd1;
   localparam logic [3:0] ACT_SUB    = 4'd2;
   localparam logic [3:0] ACT_MUL    = 4'd3;
   localparam logic [3:0] ACT_DIV    = 4'd4;
   localparam logic [3:0] ACT_MOD    = 4'd5;
   localparam logic [3:0] ACT_PRINT  = 4'd6;
   localparam logic [3:0] ACT_DUP    = 4'd7;
   localparam logic [3:0] ACT_SWAP   = 4'd8;
   localparam logic [3:0] ACT_CLEAR  = 4'd9;
   localparam logic [3:0] ACT_EOL    = 4'd10;

   // result kinds
   localparam logic [1:0] KIND_LIST = 2'd0;
   localparam logic [1:0] KIND_EOL  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_EMPTY   = 2'd0;
   localparam logic [1:0] ERR_FULL    = 2'd1;
   localparam logic [1:0] ERR_ZDIV    = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN = 2'd3;

   // divider widths: q16.16 dividend shifted up by 16, 32-bit divisor
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;

   typedef struct packed {
      logic [3:0]          action;
      logic signed [31:0]  operand_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic signed [31:0]  value;
      logic [1:0]          error_code;
      logic                last;
   } rsp_item_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_PUSH_IN,
      CMD_POP,
      CMD_CAP_B,
      CMD_CAP_A,
      CMD_EMIT_ERR,
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_MUL_FIX,
      CMD_DIV_START,
      CMD_MOD_START,
      CMD_DIV_FIX,
      CMD_MOD_FIX,
      CMD_PUSH_RES,
      CMD_PRINT_BEGIN,
      CMD_LIST_RD,
      CMD_LIST_EMIT,
      CMD_DUP_BEGIN,
      CMD_DUP_RD,
      CMD_DUP_WR,
      CMD_SWAP_BEGIN,
      CMD_SW_RD2,
      CMD_SW_WR1,
      CMD_SW_WR2,
      CMD_CLEAR,
      CMD_CLR_SEEN,
      CMD_EOL_EMIT,
      CMD_FINISH
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type  cmd;
      logic [1:0]  err_code;
   } dp_ctrl_type;

   typedef struct packed {
      logic count_zero;
      logic count_lt2;
      logic idx_zero;
      logic dup_end;
      logic b_zero;
      logic bi_zero;
      logic cmd_seen;
      logic div_done;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CAP_B,
      ST_CHK_B,
      ST_CAP_A,
      ST_ARITH,
      ST_MUL1,
      ST_MUL2,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_PUSH_R,
      ST_LIST_RD,
      ST_LIST_EMIT,
      ST_DUP_RD,
      ST_DUP_WR,
      ST_SW_RD2,
      ST_SW_WR1,
      ST_SW_WR2,
      ST_EOL_EMIT,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/rpn_divider.sv
// rpn_divider: unsigned restoring divider, one quotient bit per cycle
// 48-bit dividend by 32-bit divisor; depends on rpn_pkg
module rpn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpn_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [rpn_pkg::DIV_DEN_W-1:0] divisor,
   output logic                          done,
   output logic [rpn_pkg::DIV_NUM_W-1:0] quotient,
   output logic [rpn_pkg::DIV_DEN_W-1:0] remainder
);
   import rpn_pkg::*;

   localparam int SW = $clog2(DIV_NUM_W);
   localparam logic [SW-1:0] LAST_STEP = SW'(DIV_NUM_W - 1);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [SW-1:0]        step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // load operands on start, else one restoring step while busy
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
         step_in = step_ff + SW'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/rpn_datapath.sv
// rpn_datapath: value stack memory, operand registers, alu, divider and result buffer
// executes one command per cycle from rpn_ctrl; depends on rpn_pkg and rpn_divider
module rpn_datapath #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rpn_pkg::dp_ctrl_type   ctrl,
   input  rpn_pkg::req_item_type  req_item,
   output rpn_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output rpn_pkg::rsp_item_type  rsp_result
);
   import rpn_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   logic [31:0] mem [STACK_DEPTH];

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       limit_ff, limit_in;
   logic                seen_ff, seen_in;
   logic                pop_hit_ff, pop_hit_in;
   logic signed [31:0]  operand_ff, operand_in;
   logic signed [31:0]  a_ff, a_in;
   logic signed [31:0]  b_ff, b_in;
   logic signed [31:0]  res_ff, res_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic [31:0]         rd_data_ff;
   logic                pend_valid_ff, pend_valid_in;
   rsp_item_type        pend_ff, pend_in;
   logic                strobe_ff, strobe_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic [CW-1:0]       cnt_m1, cnt_m2, idx_m1;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                wr_en;
   logic [31:0]         wr_data;
   logic                emit_req;
   rsp_item_type        emit_item;
   logic                full;

   logic signed [32:0]  sum33;
   logic signed [63:0]  prod_adj;
   logic signed [47:0]  prod_sh;
   logic [31:0]         a_mag, b_mag;
   logic                div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                div_done;
   logic [DIV_NUM_W-1:0] div_q;
   logic [DIV_DEN_W-1:0] div_r;
   logic                q_neg;
   logic [31:0]         rem_q16;

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);
   assign idx_m1 = idx_ff - CW'(1);
   assign full   = (count_ff == DEPTH_C);

   // operand magnitudes for the divider
   assign a_mag = a_ff[31] ? 32'(-a_ff) : 32'(a_ff);
   assign b_mag = b_ff[31] ? 32'(-b_ff) : 32'(b_ff);
   assign q_neg = a_ff[31] ^ b_ff[31];
   assign rem_q16 = {div_r[15:0], 16'h0000};

   // mul: truncate toward zero on the drop of 16 fraction bits
   assign prod_adj = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
   assign prod_sh  = prod_adj[63:16];

   // divider operand select: div scales dividend by 2^16, mod uses integer parts
   always_comb begin
      div_start = 1'b0;
      div_num   = {a_mag, 16'h0000};
      div_den   = b_mag;
      unique case (ctrl.cmd)
         CMD_DIV_START: div_start = 1'b1;
         CMD_MOD_START: begin
            div_start = 1'b1;
            div_num   = {32'h0000_0000, a_mag[31:16]};
            div_den   = {16'h0000, b_mag[31:16]};
         end
         default: ;
      endcase
   end

   rpn_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // command decode
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      limit_in   = limit_ff;
      seen_in    = seen_ff;
      pop_hit_in = pop_hit_ff;
      operand_in = operand_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      res_in     = res_ff;
      prod_in    = prod_ff;
      rd_addr    = cnt_m1[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = operand_ff;
      emit_req   = 1'b0;
      emit_item  = '{kind: KIND_ERR, value: '0, error_code: ERR_EMPTY, last: 1'b0};
      sum33      = '0;
      unique case (ctrl.cmd)
         CMD_LOAD: operand_in = req_item.operand_value;
         CMD_PUSH_IN, CMD_PUSH_RES: begin
            wr_data = (ctrl.cmd == CMD_PUSH_IN) ? operand_ff : res_ff;
            if (full) begin
               emit_req             = 1'b1;
               emit_item.error_code = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            pop_hit_in = (count_ff != '0);
            if (count_ff == '0) emit_req = 1'b1;
            else count_in = cnt_m1;
         end
         CMD_CAP_B: b_in = pop_hit_ff ? $signed(rd_data_ff) : 32'sd0;
         CMD_CAP_A: a_in = pop_hit_ff ? $signed(rd_data_ff) : 32'sd0;
         CMD_EMIT_ERR: begin
            emit_req             = 1'b1;
            emit_item.error_code = ctrl.err_code;
         end
         CMD_ADD, CMD_SUB: begin
            sum33 = (ctrl.cmd == CMD_ADD) ? ({a_ff[31], a_ff} + {b_ff[31], b_ff})
                                          : ({a_ff[31], a_ff} - {b_ff[31], b_ff});
            if (sum33[32] != sum33[31]) res_in = sum33[32] ? SAT_MIN : SAT_MAX;
            else res_in = sum33[31:0];
         end
         CMD_MUL: prod_in = a_ff * b_ff;
         CMD_MUL_FIX: begin
            if (!prod_sh[47] && (prod_sh[46:31] != '0)) res_in = SAT_MAX;
            else if (prod_sh[47] && (prod_sh[46:31] != '1)) res_in = SAT_MIN;
            else res_in = prod_sh[31:0];
         end
         CMD_DIV_START, CMD_MOD_START: ;
         CMD_DIV_FIX: begin
            if (q_neg) begin
               if (div_q > 48'h0000_8000_0000) res_in = SAT_MIN;
               else res_in = 32'(-div_q);
            end else begin
               if (div_q > 48'h0000_7FFF_FFFF) res_in = SAT_MAX;
               else res_in = div_q[31:0];
            end
         end
         CMD_MOD_FIX: res_in = a_ff[31] ? 32'(-rem_q16) : rem_q16;
         CMD_PRINT_BEGIN: begin
            seen_in = 1'b1;
            idx_in  = count_ff;
            if (count_ff == '0) emit_req = 1'b1;
         end
         CMD_LIST_RD: begin
            rd_addr = idx_m1[AW-1:0];
            idx_in  = idx_m1;
         end
         CMD_LIST_EMIT: begin
            emit_req        = 1'b1;
            emit_item.kind  = KIND_LIST;
            emit_item.value = rd_data_ff;
         end
         CMD_DUP_BEGIN: begin
            seen_in  = 1'b1;
            idx_in   = '0;
            limit_in = count_ff;
            if (count_ff == '0) emit_req = 1'b1;
         end
         CMD_DUP_RD: rd_addr = idx_ff[AW-1:0];
         CMD_DUP_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            count_in = count_ff + CW'(1);
            idx_in   = idx_ff + CW'(1);
         end
         CMD_SWAP_BEGIN: begin
            seen_in = 1'b1;
            if (count_ff < CW'(2)) emit_req = 1'b1;
         end
         CMD_SW_RD2: begin
            b_in    = rd_data_ff;
            rd_addr = cnt_m2[AW-1:0];
         end
         CMD_SW_WR1: begin
            wr_en   = 1'b1;
            wr_addr = cnt_m1[AW-1:0];
            wr_data = rd_data_ff;
         end
         CMD_SW_WR2: begin
            wr_en   = 1'b1;
            wr_addr = cnt_m2[AW-1:0];
            wr_data = b_ff;
         end
         CMD_CLEAR: begin
            seen_in  = 1'b1;
            count_in = '0;
         end
         CMD_CLR_SEEN: seen_in = 1'b0;
         CMD_EOL_EMIT: begin
            emit_req        = 1'b1;
            emit_item.kind  = KIND_EOL;
            emit_item.value = pop_hit_ff ? $signed(rd_data_ff) : 32'sd0;
         end
         default: ;
      endcase
   end

   // result buffer: holds one result back so the final one of a token gets last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      strobe_in     = 1'b0;
      rsp_in        = pend_ff;
      if (emit_req) begin
         strobe_in     = pend_valid_ff;
         rsp_in.last   = 1'b0;
         pend_in       = emit_item;
         pend_valid_in = 1'b1;
      end else if (ctrl.cmd == CMD_FINISH) begin
         strobe_in     = pend_valid_ff;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         seen_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         count_ff      <= count_in;
         seen_ff       <= seen_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      limit_ff   <= limit_in;
      pop_hit_ff <= pop_hit_in;
      operand_ff <= operand_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      res_ff     <= res_in;
      prod_ff    <= prod_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   // status back to the controller
   always_comb begin
      status.count_zero = (count_ff == '0);
      status.count_lt2  = (count_ff < CW'(2));
      status.idx_zero   = (idx_ff == '0);
      status.dup_end    = (idx_ff == limit_ff) || full;
      status.b_zero     = (b_ff == '0);
      status.bi_zero    = (b_mag[31:16] == '0);
      status.cmd_seen   = seen_ff;
      status.div_done   = div_done;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_result = rsp_ff;

endmodule

// File: rtl/rpn_ctrl.sv
// rpn_ctrl: token sequencer that steps the datapath through each action
// drives datapath commands from status; depends on rpn_pkg
module rpn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [3:0]             action,
   input  rpn_pkg::dp_status_type status,
   output rpn_pkg::dp_ctrl_type   ctrl,
   output logic                   busy
);
   import rpn_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] act_ff, act_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      ctrl.cmd      = CMD_NONE;
      ctrl.err_code = ERR_EMPTY;
      busy          = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               act_in   = action;
               ctrl.cmd = CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority case (act_ff)
               ACT_NUMBER: begin
                  ctrl.cmd = CMD_PUSH_IN;
                  state_in = ST_FINISH;
               end
               ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
                  ctrl.cmd = CMD_POP;
                  state_in = ST_CAP_B;
               end
               ACT_PRINT: begin
                  ctrl.cmd = CMD_PRINT_BEGIN;
                  state_in = status.count_zero ? ST_FINISH : ST_LIST_RD;
               end
               ACT_DUP: begin
                  ctrl.cmd = CMD_DUP_BEGIN;
                  state_in = status.count_zero ? ST_FINISH : ST_DUP_RD;
               end
               ACT_SWAP: begin
                  ctrl.cmd = CMD_SWAP_BEGIN;
                  state_in = status.count_lt2 ? ST_FINISH : ST_SW_RD2;
               end
               ACT_CLEAR: begin
                  ctrl.cmd = CMD_CLEAR;
                  state_in = ST_FINISH;
               end
               ACT_EOL: begin
                  if (status.cmd_seen) begin
                     ctrl.cmd = CMD_CLR_SEEN;
                     state_in = ST_FINISH;
                  end else begin
                     ctrl.cmd = CMD_POP;
                     state_in = ST_EOL_EMIT;
                  end
               end
               default: begin
                  ctrl.cmd      = CMD_EMIT_ERR;
                  ctrl.err_code = ERR_UNKNOWN;
                  state_in      = ST_FINISH;
               end
            endcase
         end
         ST_CAP_B: begin
            ctrl.cmd = CMD_CAP_B;
            state_in = ST_CHK_B;
         end
         ST_CHK_B: begin
            if (((act_ff == ACT_DIV) && status.b_zero) ||
                ((act_ff == ACT_MOD) && status.bi_zero)) begin
               ctrl.cmd      = CMD_EMIT_ERR;
               ctrl.err_code = ERR_ZDIV;
               state_in      = ST_FINISH;
            end else begin
               ctrl.cmd = CMD_POP;
               state_in = ST_CAP_A;
            end
         end
         ST_CAP_A: begin
            ctrl.cmd = CMD_CAP_A;
            if (act_ff == ACT_MUL) state_in = ST_MUL1;
            else if ((act_ff == ACT_DIV) || (act_ff == ACT_MOD)) state_in = ST_DIV_GO;
            else state_in = ST_ARITH;
         end
         ST_ARITH: begin
            ctrl.cmd = (act_ff == ACT_SUB) ? CMD_SUB : CMD_ADD;
            state_in = ST_PUSH_R;
         end
         ST_MUL1: begin
            ctrl.cmd = CMD_MUL;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ctrl.cmd = CMD_MUL_FIX;
            state_in = ST_PUSH_R;
         end
         ST_DIV_GO: begin
            ctrl.cmd = (act_ff == ACT_MOD) ? CMD_MOD_START : CMD_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               ctrl.cmd = (act_ff == ACT_MOD) ? CMD_MOD_FIX : CMD_DIV_FIX;
               state_in = ST_PUSH_R;
            end
         end
         ST_PUSH_R: begin
            ctrl.cmd = CMD_PUSH_RES;
            state_in = ST_FINISH;
         end
         ST_LIST_RD: begin
            ctrl.cmd = CMD_LIST_RD;
            state_in = ST_LIST_EMIT;
         end
         ST_LIST_EMIT: begin
            ctrl.cmd = CMD_LIST_EMIT;
            state_in = status.idx_zero ? ST_FINISH : ST_LIST_RD;
         end
         ST_DUP_RD: begin
            if (status.dup_end) begin
               state_in = ST_FINISH;
            end else begin
               ctrl.cmd = CMD_DUP_RD;
               state_in = ST_DUP_WR;
            end
         end
         ST_DUP_WR: begin
            ctrl.cmd = CMD_DUP_WR;
            state_in = ST_DUP_RD;
         end
         ST_SW_RD2: begin
            ctrl.cmd = CMD_SW_RD2;
            state_in = ST_SW_WR1;
         end
         ST_SW_WR1: begin
            ctrl.cmd = CMD_SW_WR1;
            state_in = ST_SW_WR2;
         end
         ST_SW_WR2: begin
            ctrl.cmd = CMD_SW_WR2;
            state_in = ST_FINISH;
         end
         ST_EOL_EMIT: begin
            ctrl.cmd = CMD_EOL_EMIT;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            ctrl.cmd = CMD_FINISH;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/rpn_stack_evaluator_top.sv
// rpn_stack_evaluator_top: reverse polish stack calculator on parsed tokens, q16.16 values
// joins rpn_ctrl and rpn_datapath; depends on rpn_pkg
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+-------------------------------------
//   request  | start, busy, req_item       | beat taken when start && !busy
//   response | rsp_strobe, rsp_result      | beat valid one cycle, no backpressure
//
// div and mod share one 48-step divider; the controller handles one token at a time.
// results may leave back to back or with gaps, held one step so last can be marked;
// the final beat is on the ports in the first cycle that busy is low again.
// reset is synchronous and empties the stack; stack contents are not cleared.
module rpn_stack_evaluator_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rpn_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output rpn_pkg::rsp_item_type rsp_result
);
   import rpn_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   // sequencer
   rpn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_item.action),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // stack and arithmetic
   rpn_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_item   (req_item),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_result (rsp_result)
   );

   // accepted token keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted beat");

   // a final result is never followed directly by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_result.last |=> !rsp_strobe)
      else $error("result beat right after final beat");

   // error reports carry zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_result.kind == KIND_ERR) |-> (rsp_result.value == 32'sd0))
      else $error("error beat with nonzero value");

   // non-error results carry code zero
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_result.kind != KIND_ERR) |-> (rsp_result.error_code == ERR_EMPTY))
      else $error("non-error beat with error code");

endmodule
